// ===== rtl/core/dcr_pkg.sv =====
// Shared types and constants of the stick distance constraint pipeline.
`default_nettype none

package dcr_pkg;

    localparam int COORD_W  = 32;               // Q16.16 coordinate
    localparam int MAG_W    = COORD_W + 1;      // magnitude of a 33-bit difference
    localparam int SQ_W     = 2 * MAG_W - 1;    // one squared axis
    localparam int SUM_W    = SQ_W + 1;         // sum of two squares
    localparam int ROOT_W   = 34;               // floor sqrt of the sum
    localparam int RAD_W    = 2 * ROOT_W;       // radicand padded to whole bit pairs
    localparam int SREM_W   = ROOT_W + 3;       // sqrt partial remainder
    localparam int FRAC_W   = 16;
    localparam int DVD_W    = ROOT_W + FRAC_W;  // |rest - dist| << 16
    localparam int SPLIT_W  = DVD_W / 2;        // factor split for the multipliers
    localparam int PP_W     = MAG_W + SPLIT_W;  // one partial product
    localparam int PROD_W   = MAG_W + DVD_W;    // full offset product
    localparam int OFS_SH   = FRAC_W + 1;       // Q16.16 scaling and the half
    localparam int OMAG_W   = MAG_W + 1;        // clamped offset magnitude
    localparam int ACC_W    = COORD_W + 4;      // coordinate plus offset, no overflow
    localparam int REST_W   = 31;

    localparam logic [REST_W-1:0] REST_RESET = REST_W'(65536);

    localparam logic REG_REST   = 1'b0;
    localparam logic REG_ENABLE = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic [MAG_W-1:0]          qx;
        logic [MAG_W-1:0]          qy;
        logic                      dx_neg;
        logic                      dy_neg;
        logic                      num_neg;
        logic                      degen;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/dcr_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none

module dcr_isqrt
    import dcr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [SUM_W-1:0]  in_rad,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [ROOT_W-1:0]      out_root
);

    logic              valid_reg [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [SREM_W-1:0] rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              pv;
            side_t             ps;
            logic [RAD_W-1:0]  prad;
            logic [SREM_W-1:0] prem;
            logic [ROOT_W-1:0] proot;
            logic [SREM_W-1:0] rem_sh;
            logic [SREM_W-1:0] trial;
            logic              take;
            logic [SREM_W-1:0] rem_next;
            logic [ROOT_W-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign pv    = in_valid;
                assign ps    = in_side;
                assign prad  = RAD_W'(in_rad);
                assign prem  = '0;
                assign proot = '0;
            end
            else
            begin : g_next
                assign pv    = valid_reg[k-1];
                assign ps    = side_reg[k-1];
                assign prad  = rad_reg[k-1];
                assign prem  = rem_reg[k-1];
                assign proot = root_reg[k-1];
            end

            always_comb
            begin
                rem_sh    = {prem[SREM_W-3:0], prad[RAD_W-1 -: 2]};
                trial     = SREM_W'({proot, 2'b01});
                take      = rem_sh >= trial;
                rem_next  = take ? rem_sh - trial : rem_sh;
                root_next = {proot[ROOT_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (adv)
                    valid_reg[k] <= pv;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= ps;
                    rad_reg[k]  <= prad << 2;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/dcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module dcr_div
    import dcr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire side_t             in_side,
    input  wire logic [DVD_W-1:0]  in_dvd,
    input  wire logic [ROOT_W-1:0] in_dsr,
    output logic                   out_valid,
    output side_t                  out_side,
    output logic [DVD_W-1:0]       out_quo
);

    logic              valid_reg [DVD_W];
    side_t             side_reg  [DVD_W];
    logic [DVD_W-1:0]  dvd_reg   [DVD_W];
    logic [ROOT_W-1:0] dsr_reg   [DVD_W];
    logic [ROOT_W-1:0] rem_reg   [DVD_W];
    logic [DVD_W-1:0]  quo_reg   [DVD_W];

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++)
        begin : g_stage
            logic              pv;
            side_t             ps;
            logic [DVD_W-1:0]  pdvd;
            logic [ROOT_W-1:0] pdsr;
            logic [ROOT_W-1:0] prem;
            logic [DVD_W-1:0]  pquo;
            logic [ROOT_W:0]   rem_sh;
            logic              take;
            logic [ROOT_W:0]   rem_next;

            if (k == 0)
            begin : g_first
                assign pv   = in_valid;
                assign ps   = in_side;
                assign pdvd = in_dvd;
                assign pdsr = in_dsr;
                assign prem = '0;
                assign pquo = '0;
            end
            else
            begin : g_next
                assign pv   = valid_reg[k-1];
                assign ps   = side_reg[k-1];
                assign pdvd = dvd_reg[k-1];
                assign pdsr = dsr_reg[k-1];
                assign prem = rem_reg[k-1];
                assign pquo = quo_reg[k-1];
            end

            always_comb
            begin
                rem_sh   = {prem, pdvd[DVD_W-1]};
                take     = rem_sh >= {1'b0, pdsr};
                rem_next = take ? rem_sh - {1'b0, pdsr} : rem_sh;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (adv)
                    valid_reg[k] <= pv;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= ps;
                    dvd_reg[k]  <= pdvd << 1;
                    dsr_reg[k]  <= pdsr;
                    rem_reg[k]  <= rem_next[ROOT_W-1:0];
                    quo_reg[k]  <= {pquo[DVD_W-2:0], take};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];
    assign out_quo   = quo_reg[DVD_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/distance_constraint_relax.sv =====
// Top level of the stick distance constraint relaxation pipeline.
`default_nettype none

// One relaxation step of a two-point stick constraint on signed Q16.16
// coordinates. The block takes one stick per cycle while s_tready is high;
// in order, four stages form the differences and the exact sum of
// squares, 34 stages extract the square root one bit each, one stage forms
// |rest_length - dist| << 16, 50 stages divide it by the distance one
// quotient bit each, and three stages multiply the factor into each axis
// (split in two 33x25 partial products), clamp the offset and add it with
// saturation. The whole pipeline advances as one whenever the output
// register is empty or taken, so s_tready falls only while a result waits
// on m_tready. A disabled stick, or a stick whose endpoints coincide, passes
// its points through unchanged; the coincident case raises m_tuser.
// Write the two registers only while no transaction is in flight.
module distance_constraint_relax
    import dcr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // stick input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // first_x, first_y, second_x, second_y
    // corrected stick
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // new_first_x, new_first_y, new_second_x, new_second_y
    output logic [0:0]        m_tuser,   // degenerate
    // register port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [REST_W-1:0] rest_reg;
    logic              enable_reg;

    logic adv;

    // front stages
    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    side_t                     side0_reg, side1_reg, side2_reg, side3_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [SUM_W-1:0]          sum_reg;

    // square root
    logic                      sq_valid;
    side_t                     sq_side;
    logic [ROOT_W-1:0]         sq_root;

    // divider setup
    logic                      v4_reg;
    side_t                     side4_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [ROOT_W-1:0]         dsr_reg;
    logic signed [ROOT_W:0]    num_next;

    // divider
    logic                      dv_valid;
    side_t                     dv_side;
    logic [DVD_W-1:0]          dv_quo;

    // offset multiply and output
    logic                      v5_reg, v6_reg, v7_reg;
    side_t                     side5_reg, side6_reg;
    logic [PP_W-1:0]           pxl_reg, pxh_reg, pyl_reg, pyh_reg;
    logic [OMAG_W-1:0]         mx_reg, my_reg;
    logic [PROD_W-1:0]         prodx, prody;
    logic [PROD_W-OFS_SH-1:0]  shx, shy;
    logic [127:0]              data_reg;
    logic                      degen_reg;

    function automatic logic [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] base,
        input logic [OMAG_W-1:0]         mag,
        input logic                      neg
    );
        logic signed [ACC_W-1:0] ext;
        logic signed [ACC_W-1:0] acc;
        ext = $signed(ACC_W'(mag));
        acc = ACC_W'(base) + (neg ? -ext : ext);
        if (acc > ACC_W'(32'sh7FFF_FFFF))
            sat_add = 32'h7FFF_FFFF;
        else if (acc < -ACC_W'(64'sh8000_0000))
            sat_add = 32'h8000_0000;
        else
            sat_add = acc[COORD_W-1:0];
    endfunction

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg   <= REST_RESET;
            enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_REST:   rest_reg   <= pwdata[REST_W-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_REST:   prdata = {1'b0, rest_reg};
            REG_ENABLE: prdata = {31'b0, enable_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance everything together unless a finished result is held.
    assign adv      = !v7_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sq_valid;
            v5_reg <= dv_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // ---------------- front: capture, differences, squares, sum ----------------
    always_ff @(posedge clk)
    begin
        side_t                   cap;
        side_t                   diff;
        logic signed [MAG_W-1:0] dx;
        logic signed [MAG_W-1:0] dy;
        if (adv)
        begin
            // capture
            cap               = '0;
            cap.fx            = s_tdata[31:0];
            cap.fy            = s_tdata[63:32];
            cap.sx            = s_tdata[95:64];
            cap.sy            = s_tdata[127:96];
            side0_reg         <= cap;

            // differences, kept as sign and magnitude
            dx = MAG_W'(side0_reg.fx) - MAG_W'(side0_reg.sx);
            dy = MAG_W'(side0_reg.fy) - MAG_W'(side0_reg.sy);
            diff              = side0_reg;
            diff.dx_neg       = dx[MAG_W-1];
            diff.dy_neg       = dy[MAG_W-1];
            diff.qx           = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            diff.qy           = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            side1_reg         <= diff;

            // squares
            side2_reg         <= side1_reg;
            sqx_reg           <= SQ_W'(side1_reg.qx) * SQ_W'(side1_reg.qx);
            sqy_reg           <= SQ_W'(side1_reg.qy) * SQ_W'(side1_reg.qy);

            // exact sum of squares
            side3_reg         <= side2_reg;
            sum_reg           <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        end
    end

    dcr_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_side   (side3_reg),
        .in_rad    (sum_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // ---------------- divider setup: |rest - dist| << 16 over dist ----------------
    assign num_next = $signed({4'b0, rest_reg}) - $signed({1'b0, sq_root});

    always_ff @(posedge clk)
    begin
        side_t setup;
        if (adv)
        begin
            setup             = sq_side;
            setup.degen       = sq_root == '0;
            setup.num_neg     = num_next[ROOT_W];
            side4_reg         <= setup;
            dvd_reg           <= {(num_next[ROOT_W] ? ROOT_W'(-num_next)
                                                    : ROOT_W'(num_next)),
                                  {FRAC_W{1'b0}}};
            dsr_reg           <= sq_root;
        end
    end

    dcr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_side   (side4_reg),
        .in_dvd    (dvd_reg),
        .in_dsr    (dsr_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // ---------------- offsets: |d| * |factor| >> 17, clamped ----------------
    assign prodx = PROD_W'(pxl_reg) + (PROD_W'(pxh_reg) << SPLIT_W);
    assign prody = PROD_W'(pyl_reg) + (PROD_W'(pyh_reg) << SPLIT_W);
    assign shx   = prodx[PROD_W-1:OFS_SH];
    assign shy   = prody[PROD_W-1:OFS_SH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // split multiply
            side5_reg <= dv_side;
            pxl_reg   <= PP_W'(dv_side.qx) * PP_W'(dv_quo[SPLIT_W-1:0]);
            pxh_reg   <= PP_W'(dv_side.qx) * PP_W'(dv_quo[DVD_W-1:SPLIT_W]);
            pyl_reg   <= PP_W'(dv_side.qy) * PP_W'(dv_quo[SPLIT_W-1:0]);
            pyh_reg   <= PP_W'(dv_side.qy) * PP_W'(dv_quo[DVD_W-1:SPLIT_W]);

            // combine and clamp: anything at or above 2^33 saturates anyway
            side6_reg <= side5_reg;
            mx_reg    <= (shx >= (PROD_W-OFS_SH)'(1) << MAG_W)
                         ? OMAG_W'(1) << MAG_W : OMAG_W'(shx);
            my_reg    <= (shy >= (PROD_W-OFS_SH)'(1) << MAG_W)
                         ? OMAG_W'(1) << MAG_W : OMAG_W'(shy);

            // apply offsets, or pass through
            if (!enable_reg || side6_reg.degen)
            begin
                data_reg  <= {side6_reg.sy, side6_reg.sx, side6_reg.fy, side6_reg.fx};
                degen_reg <= enable_reg;
            end
            else
            begin
                data_reg[31:0]   <= sat_add(side6_reg.fx, mx_reg,
                                            side6_reg.dx_neg ^ side6_reg.num_neg);
                data_reg[63:32]  <= sat_add(side6_reg.fy, my_reg,
                                            side6_reg.dy_neg ^ side6_reg.num_neg);
                data_reg[95:64]  <= sat_add(side6_reg.sx, mx_reg,
                                            !(side6_reg.dx_neg ^ side6_reg.num_neg));
                data_reg[127:96] <= sat_add(side6_reg.sy, my_reg,
                                            !(side6_reg.dy_neg ^ side6_reg.num_neg));
                degen_reg        <= 1'b0;
            end
        end
    end

    assign m_tvalid   = v7_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = degen_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dcr_checker.sv =====
// Port-level checker for the stick constraint block and its bind.
`default_nettype none

module dcr_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [0:0]   m_tuser,
    input wire logic         pready
);

    // A held result keeps its value until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input is open exactly when the output register can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    // No result during reset.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Register port never waits.
    assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind distance_constraint_relax dcr_checker u_dcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
